// ===== rtl/core/adc_block_fir_convolver_unit_defines.svh =====
// Assertion macros used by the checker file.
`ifndef ADC_BLOCK_FIR_CONVOLVER_UNIT_DEFINES_SVH
`define ADC_BLOCK_FIR_CONVOLVER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define ADCFIR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ADCFIR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/adcfir_pkg.sv =====
`default_nettype none

package adcfir_pkg;

   localparam int RAW_W      = 12;
   localparam int MV_W       = 11;
   localparam int COEF_W     = 16;
   localparam int IDX_W      = 8;
   localparam int TAIL_W     = 3;
   localparam int CSR_IDX_W  = 8;
   localparam int NUM_REGS   = 4;
   localparam int MV_FULL    = 1200;
   localparam int RAW_FULL   = 4095;
   // raw * 1200 fits in 23 bits
   localparam int SCALED_W   = 23;
   localparam int REM_W      = RAW_W + 1;

   localparam int BLOCK_LEN_DEFAULT = 128;
   localparam int TAP_COUNT_DEFAULT = 4;

   localparam logic [CSR_IDX_W-1:0] REG_TAP_ZERO  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_TAP_ONE   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_TAP_TWO   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_TAP_THREE = CSR_IDX_W'(3);

   typedef logic [MV_W-1:0]   mv_type;
   typedef logic [COEF_W-1:0] coef_type;
   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [TAIL_W-1:0] tail_type;

endpackage

`default_nettype wire

// ===== rtl/core/adc_block_fir_convolver_unit.sv =====
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  req_tdata[11:0] raw_sample
// rsp      out  rsp_tvalid/rsp_tready  rsp_tdata value/index, rsp_tlast end_of_run
// csr      in   csr_valid/csr_ready    csr_index, csr_data (tap write)
//
// Takes one sample per cycle unless stalled; it passes stages 1, 2, 3 and the output register.
// The last sample of a block holds the emit stage for TAP_COUNT results, one per emit.
// Reset is synchronous: clears history, block position, stage valids, taps to 1..4.
// Stalls on rsp ripple back through the stage ready chain; csr is always ready.
`default_nettype none

module adc_block_fir_convolver_unit
   import adcfir_pkg::*;
#(
   parameter int BLOCK_LEN = BLOCK_LEN_DEFAULT,
   parameter int TAP_COUNT = TAP_COUNT_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [15:0]          req_tdata,   // [11:0] raw_sample, [15:12] zero
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [23:0]               rsp_tdata,   // [15:0] filtered_value, [23:16] output_index
   output logic                      rsp_tlast,   // end_of_run
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [COEF_W-1:0]    csr_data
);

   localparam int POS_W      = $clog2(BLOCK_LEN);
   localparam int HIST_DEPTH = (TAP_COUNT > 1) ? TAP_COUNT - 1 : 1;

   // configuration
   coef_type taps_ff [NUM_REGS];

   // stage 1: raw sample
   logic              r_valid_ff;
   logic [RAW_W-1:0]  raw_ff;

   // block state
   mv_type            hist_ff [HIST_DEPTH];
   logic [POS_W-1:0]  pos_ff;

   // stage 2: window, emits one result per cycle while stage 3 can load
   logic              w_valid_ff;
   mv_type            w_ff [TAP_COUNT];
   idx_type           w_idx_ff;
   tail_type          w_tails_ff;

   // stage 3: products
   logic              p_valid_ff;
   coef_type          p_ff [TAP_COUNT];
   idx_type           p_idx_ff;
   logic              p_last_ff;

   // output register
   logic              rsp_valid_ff;
   coef_type          rsp_value_ff;
   idx_type           rsp_idx_ff;
   logic              rsp_last_ff;

   logic                 out_load, p_load, w_fire, w_done, w_load, r_fire, r_load;
   logic [SCALED_W-1:0]  scaled;
   mv_type               q_lo;
   logic [REM_W-1:0]     rem;
   mv_type               mv;
   mv_type               new_win [TAP_COUNT];
   logic                 blk_last;
   coef_type             tap_val [TAP_COUNT];
   coef_type             prod_in [TAP_COUNT];
   coef_type             sum;

   // ready chain
   assign out_load   = !rsp_valid_ff || rsp_tready;
   assign p_load     = !p_valid_ff || out_load;
   assign w_fire     = w_valid_ff && p_load;
   assign w_done     = w_fire && (w_tails_ff == '0);
   assign w_load     = !w_valid_ff || w_done;
   assign r_fire     = r_valid_ff && w_load;
   assign r_load     = !r_valid_ff || w_load;
   assign req_tready = r_load;
   assign csr_ready  = 1'b1;

   // floor(raw*1200/4095): estimate by /4096, then one correction step
   always_comb begin
      scaled = SCALED_W'(raw_ff) * SCALED_W'(MV_FULL);
      q_lo   = scaled[SCALED_W-1:RAW_W];
      rem    = REM_W'(scaled[RAW_W-1:0]) + REM_W'(q_lo);
      mv     = q_lo + MV_W'(rem >= REM_W'(RAW_FULL));
   end

   always_comb begin
      new_win[0] = mv;
      for (int i = 1; i < TAP_COUNT; i++) begin
         new_win[i] = hist_ff[i-1];
      end
   end

   assign blk_last = (pos_ff == POS_W'(BLOCK_LEN - 1));

   // taps past the fourth read as zero
   always_comb begin
      for (int j = 0; j < TAP_COUNT; j++) begin
         tap_val[j] = (j < NUM_REGS) ? taps_ff[j % NUM_REGS] : '0;
         prod_in[j] = COEF_W'(tap_val[j] * COEF_W'(w_ff[j]));
      end
   end

   always_comb begin
      sum = '0;
      for (int j = 0; j < TAP_COUNT; j++) begin
         sum = sum + p_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taps_ff[0] <= COEF_W'(1);
         taps_ff[1] <= COEF_W'(2);
         taps_ff[2] <= COEF_W'(3);
         taps_ff[3] <= COEF_W'(4);
      end else if (csr_valid) begin
         case (csr_index)
            REG_TAP_ZERO:  taps_ff[0] <= csr_data;
            REG_TAP_ONE:   taps_ff[1] <= csr_data;
            REG_TAP_TWO:   taps_ff[2] <= csr_data;
            REG_TAP_THREE: taps_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   // stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else if (r_load) begin
         r_valid_ff <= req_tvalid;
      end
      if (r_load && req_tvalid) begin
         raw_ff <= req_tdata[RAW_W-1:0];
      end
   end

   // block state follows each sample as it enters stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else if (r_fire) begin
         pos_ff <= blk_last ? '0 : pos_ff + POS_W'(1);
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_ff[i] <= blk_last ? '0 : new_win[i % TAP_COUNT];
         end
      end
   end

   // stage 2: tails shift the window toward older taps, zero filling
   always_ff @(posedge clock) begin
      if (reset) begin
         w_valid_ff <= 1'b0;
      end else if (r_fire) begin
         w_valid_ff <= 1'b1;
      end else if (w_done) begin
         w_valid_ff <= 1'b0;
      end
      if (r_fire) begin
         w_ff       <= new_win;
         w_idx_ff   <= IDX_W'(pos_ff);
         w_tails_ff <= blk_last ? TAIL_W'(TAP_COUNT - 1) : '0;
      end else if (w_fire) begin
         w_ff[0] <= '0;
         for (int i = 1; i < TAP_COUNT; i++) begin
            w_ff[i] <= w_ff[i-1];
         end
         w_idx_ff   <= w_idx_ff + IDX_W'(1);
         w_tails_ff <= w_tails_ff - TAIL_W'(1);
      end
   end

   // stage 3
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (p_load) begin
         p_valid_ff <= w_valid_ff;
      end
      if (w_fire) begin
         p_ff      <= prod_in;
         p_idx_ff  <= w_idx_ff;
         p_last_ff <= (w_tails_ff == '0);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= p_valid_ff;
      end
      if (out_load && p_valid_ff) begin
         rsp_value_ff <= sum;
         rsp_idx_ff   <= p_idx_ff;
         rsp_last_ff  <= p_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_idx_ff, rsp_value_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/adcfir_checker.sv =====
`default_nettype none

`include "adc_block_fir_convolver_unit_defines.svh"

module adcfir_checker
   import adcfir_pkg::*;
#(
   parameter int TAP_COUNT = TAP_COUNT_DEFAULT
) (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_tvalid,
   input wire logic                 rsp_tready,
   input wire logic [23:0]          rsp_tdata,
   input wire logic                 rsp_tlast
);

   logic        rsp_xact;
   logic        rsp_stall;
   logic [25:0] rsp_word;
   idx_type     rsp_idx;
   idx_type     idx_next;
   logic        prev_open_ff;
   idx_type     prev_idx_ff;
   tail_type    run_ff;

   assign rsp_xact  = rsp_tvalid && rsp_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_word  = {rsp_tvalid, rsp_tlast, rsp_tdata};
   assign rsp_idx   = rsp_tdata[23:16];
   assign idx_next  = prev_idx_ff + IDX_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_open_ff <= 1'b0;
         run_ff       <= '0;
      end else if (rsp_xact) begin
         prev_open_ff <= !rsp_tlast;
         prev_idx_ff  <= rsp_idx;
         run_ff       <= rsp_tlast ? '0 : run_ff + TAIL_W'(1);
      end
   end

   `ADCFIR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, $stable(rsp_word), "rsp changed while stalled")
   `ADCFIR_ASSERT_NOW(a_tail_index, clock, reset, rsp_xact && prev_open_ff, rsp_idx == idx_next, "tail index skipped")
   `ADCFIR_ASSERT_NOW(a_tail_count, clock, reset, rsp_xact && !rsp_tlast, run_ff < TAIL_W'(TAP_COUNT - 1), "too many results")
   `ADCFIR_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid, "result pending after reset")

endmodule

bind adc_block_fir_convolver_unit adcfir_checker #(
   .TAP_COUNT(TAP_COUNT)
) u_adcfir_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ===== test/tb_adc_block_fir_convolver_unit.sv =====
module tb_adc_block_fir_convolver_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import adcfir_pkg::*;

   localparam int BLOCK_LEN     = BLOCK_LEN_DEFAULT;
   localparam int TAP_COUNT     = TAP_COUNT_DEFAULT;
   localparam int MAX_TAPS      = 8;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 12;
   localparam int LONG_HOLD     = 160;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 45;

   typedef struct packed {
      logic [15:0] value;
      idx_type     index;
      logic        last;
   } conv_result_type;

   class fir_scoreboard;
      coef_type        taps [NUM_REGS];
      mv_type          history [MAX_TAPS];   // newest first
      int unsigned     position;
      conv_result_type pending_sums [$];
      int unsigned     mismatches;

      function new();
         taps[0]    = 16'd1;
         taps[1]    = 16'd2;
         taps[2]    = 16'd3;
         taps[3]    = 16'd4;
         foreach (history[i]) history[i] = '0;
         position   = 0;
         mismatches = 0;
      endfunction

      // taps beyond the register file read as zero
      function coef_type tap_at(int unsigned j);
         return (j < NUM_REGS) ? taps[j] : '0;
      endfunction

      function void write_tap(logic [CSR_IDX_W-1:0] idx, coef_type data);
         if (idx < NUM_REGS) taps[idx] = data;
      endfunction

      function void convolve_sample(logic [RAW_W-1:0] raw);
         int unsigned     win [MAX_TAPS];
         int unsigned     acc;
         bit              at_end;
         conv_result_type r;
         win[0] = (MV_FULL * int'(raw)) / RAW_FULL;
         for (int i = 1; i < MAX_TAPS; i++) win[i] = history[i-1];
         at_end = (position >= BLOCK_LEN - 1);

         acc = 0;
         for (int j = 0; j < TAP_COUNT && j < MAX_TAPS; j++)
            acc = (acc + tap_at(j) * win[j]) & 32'hFFFF;
         r.value = acc[15:0];
         r.index = position[IDX_W-1:0];
         r.last  = !at_end || (TAP_COUNT <= 1);
         pending_sums.push_back(r);

         if (at_end) begin
            // flush the tail of the full convolution
            for (int m = 1; m < TAP_COUNT && m < MAX_TAPS; m++) begin
               acc = 0;
               for (int j = m; j < TAP_COUNT && j < MAX_TAPS; j++)
                  acc = (acc + tap_at(j) * win[j-m]) & 32'hFFFF;
               r.value = acc[15:0];
               r.index = IDX_W'(position + m);
               r.last  = (m == TAP_COUNT - 1);
               pending_sums.push_back(r);
            end
            foreach (history[i]) history[i] = '0;
            position = 0;
         end else begin
            for (int i = MAX_TAPS - 1; i > 0; i--) history[i] = history[i-1];
            history[0] = mv_type'(win[0]);
            position++;
         end
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH at %0t: %s", $time, msg);
         mismatches++;
      endtask

      task check_output(logic [15:0] value, idx_type index, logic last);
         conv_result_type want;
         if (pending_sums.size() == 0) begin
            report_mismatch($sformatf("unexpected result value=%0d index=%0d last=%0b",
                                      value, index, last));
         end else begin
            want = pending_sums.pop_front();
            if (value !== want.value)
               report_mismatch($sformatf("filtered_value %0d, want %0d (index %0d)",
                                         value, want.value, want.index));
            if (index !== want.index)
               report_mismatch($sformatf("output_index %0d, want %0d", index, want.index));
            if (last !== want.last)
               report_mismatch($sformatf("end_of_run %0b, want %0b (index %0d)",
                                         last, want.last, want.index));
         end
      endtask
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [15:0]          req_tdata;    // [11:0] raw_sample, [15:12] zero
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [23:0]          rsp_tdata;    // [15:0] filtered_value, [23:16] output_index
   logic                 rsp_tlast;    // end_of_run
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   coef_type             csr_data;

   fir_scoreboard fir;
   int unsigned   hold_requests = 0;
   int unsigned   cycle_count = 0;
   int unsigned   burst_left = 0;

   adc_block_fir_convolver_unit #(
      .BLOCK_LEN (BLOCK_LEN),
      .TAP_COUNT (TAP_COUNT)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         fir.check_output(rsp_tdata[15:0], rsp_tdata[23:16], rsp_tlast);
   end

   // receiver: randomly chosen stall modes, plus an occasional long hold-off
   initial begin
      int unsigned mode;
      int unsigned mode_left;
      int unsigned hold_left;
      int unsigned holds_served;
      mode         = 0;
      mode_left    = 0;
      hold_left    = 0;
      holds_served = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = LONG_HOLD;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 80);
         end
         mode_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= (mode_left % 3 == 0);
               default: rsp_tready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // sender runs in bursts; valid stays high between transactions of a burst
   task automatic offer_sample(input logic [RAW_W-1:0] raw);
      int unsigned gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            req_tdata  <= 16'($urandom_range(0, 4095));
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, raw};
      do @(posedge clock); while (!req_tready);
      fir.convolve_sample(raw);
   endtask

   task automatic end_phase();
      req_tvalid <= 1'b0;
      while (fir.pending_sums.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // writes all four taps, then junk extra writes to indexes past the register file
   task automatic load_taps(input coef_type t0, input coef_type t1, input coef_type t2,
                            input coef_type t3, input int unsigned junk);
      logic [CSR_IDX_W-1:0] regs [NUM_REGS];
      coef_type             vals [NUM_REGS];
      logic [CSR_IDX_W-1:0] idx;
      coef_type             data;
      regs = '{REG_TAP_ZERO, REG_TAP_ONE, REG_TAP_TWO, REG_TAP_THREE};
      vals = '{t0, t1, t2, t3};
      for (int i = 0; i < NUM_REGS + junk; i++) begin
         if (i < NUM_REGS) begin
            idx  = regs[i];
            data = vals[i];
         end else begin
            idx  = (i == NUM_REGS) ? '1 : CSR_IDX_W'($urandom_range(NUM_REGS, 255));
            data = coef_type'($urandom);
         end
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data  <= data;
         do @(posedge clock); while (!csr_ready);
         fir.write_tap(idx, data);
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic coef_type pick_tap();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         2: return coef_type'($urandom_range(0, 15));
         default: return coef_type'($urandom);
      endcase
   endfunction

   initial begin
      logic [RAW_W-1:0] corners [$];
      logic [RAW_W-1:0] raw;
      fir = new();
      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      csr_valid    <= 1'b0;
      csr_index    <= '0;
      csr_data     <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // taps at their reset values; scaling corners and bit patterns
      corners = '{12'h000, 12'hFFF, 12'h001, 12'hFFE, 12'h003, 12'h004,
                  12'h800, 12'hAAA, 12'h555, 12'd3412, 12'd3413};
      foreach (corners[i]) offer_sample(corners[i]);
      end_phase();

      // all taps at maximum: accumulator wraps
      load_taps('1, '1, '1, '1, 0);
      corners = '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'h000, 12'hFFF};
      foreach (corners[i]) offer_sample(corners[i]);
      end_phase();

      load_taps('0, '0, '0, '0, 1);
      corners = '{12'hFFF, 12'd1234};
      foreach (corners[i]) offer_sample(corners[i]);
      end_phase();

      load_taps(16'd1, '0, '0, '1, 2);
      corners = '{12'hFFF, 12'h000, 12'h000, 12'h000, 12'hFFF};
      foreach (corners[i]) offer_sample(corners[i]);
      end_phase();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         load_taps(pick_tap(), pick_tap(), pick_tap(), pick_tap(), $urandom_range(0, 2));
         // back up the pipeline while the sender keeps offering
         if (p == 1 || p == 4) hold_requests <= hold_requests + 1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 7) == 0)
               raw = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            else
               raw = RAW_W'($urandom);
            offer_sample(raw);
         end
         end_phase();
      end

      if (fir.mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
